// File: hdl/sbcp_pkg.sv
// Shared widths, codes and types of the segment black-cell probe.
package sbcp_pkg;

	// Field widths of requests and configuration.
	localparam int COORD_W     = 8;
	localparam int CLASS_W     = 2;
	localparam int DIM_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int COORD_RANGE = 1 << COORD_W;

	// Default raster limits.
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CLASS_W-1:0] cell_class_t;
	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RASTER_VALID  = 2'd0,
		REG_RASTER_WIDTH  = 2'd1,
		REG_RASTER_HEIGHT = 2'd2
	} cfg_reg_t;

	// Request kinds.
	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	// Cell class that marks a black cell.
	localparam cell_class_t CLASS_BLACK = 2'd2;

endpackage

// File: hdl/sbcp_ifs.sv
// Handshake interfaces of the segment black-cell probe: request, result and configuration.
interface sbcp_req_if;
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	sbcp_pkg::coord_t     cell_x;
	sbcp_pkg::coord_t     cell_y;
	sbcp_pkg::cell_class_t cell_class;
	sbcp_pkg::coord_t     start_x;
	sbcp_pkg::coord_t     start_y;
	sbcp_pkg::coord_t     end_x;
	sbcp_pkg::coord_t     end_y;

	modport source (
		output valid, req_type, cell_x, cell_y, cell_class, start_x, start_y, end_x, end_y,
		input  ready
	);
	modport sink (
		input  valid, req_type, cell_x, cell_y, cell_class, start_x, start_y, end_x, end_y,
		output ready
	);
endinterface

interface sbcp_res_if;
	logic valid;
	logic ready;
	logic touches_black;
	logic endpoint_outside;

	modport source (
		output valid, touches_black, endpoint_outside,
		input  ready
	);
	modport sink (
		input  valid, touches_black, endpoint_outside,
		output ready
	);
endinterface

interface sbcp_cfg_if;
	logic                  valid;
	logic                  ready;
	sbcp_pkg::cfg_index_t  index;
	sbcp_pkg::dim_t        data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: hdl/segment_black_cell_probe.sv
// Black-cell map with a Bresenham segment probe, top level.
// A cell write leaves the block idle, so it is ready again in the next cycle.
// A rejected query goes through the done state into the output register. An accepted
// query reads one map cell per cycle through the single RAM port and stops on a black hit.
// After reset a clearing pass writes every map entry once, EFF_W*EFF_H entries (65536 at the
// defaults), while requests are held off; configuration writes are taken at all times.
module segment_black_cell_probe #(
	parameter int MAX_WIDTH  = sbcp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sbcp_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	sbcp_req_if.sink    req,
	sbcp_res_if.source  res,
	sbcp_cfg_if.sink    cfg
);

	// Only cells that an 8-bit coordinate can reach are stored.
	localparam int EFF_W  = (MAX_WIDTH  < sbcp_pkg::COORD_RANGE) ? MAX_WIDTH
		: sbcp_pkg::COORD_RANGE;
	localparam int EFF_H  = (MAX_HEIGHT < sbcp_pkg::COORD_RANGE) ? MAX_HEIGHT
		: sbcp_pkg::COORD_RANGE;
	localparam int DEPTH  = EFF_W * EFF_H;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int DIFF_W = sbcp_pkg::DIM_W + 1;
	localparam int ERR_W  = sbcp_pkg::DIM_W + 3;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	function automatic logic in_bounds(sbcp_pkg::coord_t x, sbcp_pkg::coord_t y,
		sbcp_pkg::dim_t w, sbcp_pkg::dim_t h);
		return ({1'b0, x} < w) && (32'(x) < MAX_WIDTH)
			&& ({1'b0, y} < h) && (32'(y) < MAX_HEIGHT);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(sbcp_pkg::coord_t x, sbcp_pkg::coord_t y);
		return ADDR_W'(32'(y) * EFF_W + 32'(x));
	endfunction

	state_t                     state_q;
	logic [ADDR_W-1:0]          clr_cnt_q;
	logic                       raster_valid_q;
	sbcp_pkg::dim_t             raster_width_q;
	sbcp_pkg::dim_t             raster_height_q;

	sbcp_pkg::coord_t           x_q, y_q, xe_q, ye_q;
	logic signed [DIFF_W-1:0]   dx_q, dy_q;
	logic                       sx_neg_q, sy_neg_q;
	logic signed [ERR_W-1:0]    err_q;
	logic                       pend_q, pend_last_q;
	logic                       res_black_q, res_outside_q;
	logic                       out_valid_q, out_black_q, out_outside_q;

	logic                       in_acc;
	logic                       is_query;
	logic                       wr_en;
	logic                       query_ok;
	logic                       walk_issue;
	logic                       walk_hit, walk_end;
	logic                       out_load;
	logic                       ram_en, ram_we, ram_wdata, ram_rdata;
	logic [ADDR_W-1:0]          ram_addr;
	logic signed [DIFF_W-1:0]   ddx, ddy, adx, ady;
	logic signed [ERR_W:0]      e2;
	logic                       step_x, step_y;
	logic signed [ERR_W-1:0]    err_nxt;
	sbcp_pkg::coord_t           x_nxt, y_nxt;

	// Handshakes.
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign in_acc    = req.valid && req.ready;
	assign is_query  = (req.req_type == sbcp_pkg::REQ_QUERY);
	assign wr_en     = in_acc && !is_query
		&& in_bounds(req.cell_x, req.cell_y, raster_width_q, raster_height_q);
	assign query_ok  = raster_valid_q
		&& in_bounds(req.start_x, req.start_y, raster_width_q, raster_height_q)
		&& in_bounds(req.end_x, req.end_y, raster_width_q, raster_height_q);

	// Segment setup: absolute deltas, dy kept negative as in the classic form.
	always_comb begin
		ddx = signed'({2'b00, req.end_x}) - signed'({2'b00, req.start_x});
		ddy = signed'({2'b00, req.end_y}) - signed'({2'b00, req.start_y});
		adx = ddx[DIFF_W-1] ? -ddx : ddx;
		ady = ddy[DIFF_W-1] ? -ddy : ddy;
	end

	// Stepping unit: one Bresenham step per issued cell.
	always_comb begin
		e2      = signed'({err_q, 1'b0});
		step_x  = (e2 >= (ERR_W + 1)'(dy_q));
		step_y  = (e2 <= (ERR_W + 1)'(dx_q));
		err_nxt = err_q + (step_x ? ERR_W'(dy_q) : '0) + (step_y ? ERR_W'(dx_q) : '0);
		x_nxt   = x_q;
		y_nxt   = y_q;
		if (step_x) begin
			x_nxt = sx_neg_q ? x_q - 1'b1 : x_q + 1'b1;
		end
		if (step_y) begin
			y_nxt = sy_neg_q ? y_q - 1'b1 : y_q + 1'b1;
		end
	end

	// The walk stops on a black cell or once the end cell has been read.
	assign walk_hit   = pend_q && ram_rdata;
	assign walk_end   = pend_q && pend_last_q;
	assign walk_issue = (state_q == ST_WALK) && !walk_hit && !walk_end;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || res.ready);

	// Map port selection: clearing pass, cell write or walk read.
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = 1'b0;
		ram_addr  = cell_addr(x_q, y_q);
		if (state_q == ST_CLEAR) begin
			ram_en   = 1'b1;
			ram_we   = 1'b1;
			ram_addr = clr_cnt_q;
		end else if (wr_en) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_wdata = (req.cell_class == sbcp_pkg::CLASS_BLACK);
			ram_addr  = cell_addr(req.cell_x, req.cell_y);
		end else if (walk_issue) begin
			ram_en = 1'b1;
		end
	end

	sbcp_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_valid_q  <= 1'b0;
			raster_width_q  <= sbcp_pkg::DIM_W'(2);
			raster_height_q <= sbcp_pkg::DIM_W'(2);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				sbcp_pkg::REG_RASTER_VALID:  raster_valid_q  <= cfg.data[0];
				sbcp_pkg::REG_RASTER_WIDTH:  raster_width_q  <= cfg.data;
				sbcp_pkg::REG_RASTER_HEIGHT: raster_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_acc && is_query) begin
						pend_q  <= 1'b0;
						state_q <= query_ok ? ST_WALK : ST_DONE;
					end
				end
				ST_WALK: begin
					if (walk_hit || walk_end) begin
						pend_q  <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						pend_q      <= 1'b1;
						pend_last_q <= (x_q == xe_q) && (y_q == ye_q);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Walk datapath and pending result.
	always_ff @(posedge clk) begin
		if (in_acc && is_query) begin
			x_q           <= req.start_x;
			y_q           <= req.start_y;
			xe_q          <= req.end_x;
			ye_q          <= req.end_y;
			dx_q          <= adx;
			dy_q          <= -ady;
			sx_neg_q      <= (req.end_x < req.start_x);
			sy_neg_q      <= (req.end_y < req.start_y);
			err_q         <= ERR_W'(adx) - ERR_W'(ady);
			res_black_q   <= 1'b0;
			res_outside_q <= !query_ok;
		end else if (state_q == ST_WALK) begin
			if (walk_hit) begin
				res_black_q <= 1'b1;
			end else if (walk_issue) begin
				x_q   <= x_nxt;
				y_q   <= y_nxt;
				err_q <= err_nxt;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_black_q   <= res_black_q;
			out_outside_q <= res_outside_q;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.touches_black    = out_black_q;
	assign res.endpoint_outside = out_outside_q;

endmodule

// File: hdl/sbcp_ram.sv
// Generic single-port RAM with registered read data.
module sbcp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read before write: a write cycle returns the old contents on the same port.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata <= mem_q[addr];
		end
	end

endmodule

// File: hdl/sbcp_checker.sv
// Port-level checker of the segment black-cell probe and its bind.
module sbcp_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic req_type,
	input logic res_valid,
	input logic res_ready,
	input logic res_touches_black,
	input logic res_endpoint_outside
);

	// No result is shown while reset is applied.
	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |-> (res_valid !== 1'b1))
		else $error("result valid during reset");

	// A stalled result holds its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_touches_black)
			&& $stable(res_endpoint_outside))
		else $error("stalled result changed");

	// A black hit is never reported together with the outside flag.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_touches_black && res_endpoint_outside))
		else $error("black hit reported with outside flag");

	// A query occupies the block: no request is taken in the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == sbcp_pkg::REQ_QUERY) |=> !req_ready)
		else $error("request taken right after a query");

endmodule

bind segment_black_cell_probe sbcp_checker u_sbcp_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.req_valid            (req.valid),
	.req_ready            (req.ready),
	.req_type             (req.req_type),
	.res_valid            (res.valid),
	.res_ready            (res.ready),
	.res_touches_black    (res.touches_black),
	.res_endpoint_outside (res.endpoint_outside)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the segment black-cell probe: directed table, then random phases.
module tb;

	localparam int MAX_W           = sbcp_pkg::DEF_MAX_WIDTH;
	localparam int MAX_H           = sbcp_pkg::DEF_MAX_HEIGHT;
	localparam int WRITE_SETTLE    = 4;
	localparam int TAIL_CYCLES     = 16;
	localparam int HOLD_CYCLES     = 400;
	localparam int RANDOM_PHASES   = 10;
	localparam int ITEMS_PER_PHASE = 45;

	// Register index past the three real registers; the block ignores it.
	localparam sbcp_pkg::cfg_index_t REG_SPARE = 2'd3;

	// Cell classes other than black.
	localparam sbcp_pkg::cell_class_t CLS_INVALID = 2'd0;
	localparam sbcp_pkg::cell_class_t CLS_UNKNOWN = 2'd1;
	localparam sbcp_pkg::cell_class_t CLS_WHITE   = 2'd3;

	typedef struct packed {
		sbcp_pkg::req_kind_t   kind;
		sbcp_pkg::coord_t      cell_x;
		sbcp_pkg::coord_t      cell_y;
		sbcp_pkg::cell_class_t cls;
		sbcp_pkg::coord_t      sx;
		sbcp_pkg::coord_t      sy;
		sbcp_pkg::coord_t      ex;
		sbcp_pkg::coord_t      ey;
	} probe_req_t;

	typedef struct packed {
		logic touches_black;
		logic endpoint_outside;
	} probe_res_t;

	// One row of the directed table: a register write or a request.
	typedef struct packed {
		bit                   is_cfg;
		sbcp_pkg::cfg_index_t idx;
		sbcp_pkg::dim_t       data;
		probe_req_t           rq;
		bit                   typed;
		probe_res_t           want;
	} step_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sbcp_req_if req_bus ();
	sbcp_res_if res_bus ();
	sbcp_cfg_if cfg_bus ();

	segment_black_cell_probe DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	// Predicted state of the block.
	bit             map_black_bits [MAX_W*MAX_H];
	bit             raster_on;
	sbcp_pkg::dim_t raster_cols;
	sbcp_pkg::dim_t raster_rows;

	probe_res_t expected_probe_results [$];
	step_row_t  directed_steps [$];
	int         mismatch_count;
	bit         idling_on;
	bit         hold_results;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit, far above the slowest correct run including the clearing pass.
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int used_extent(sbcp_pkg::dim_t d, int cap);
		return (int'(d) < cap) ? int'(d) : cap;
	endfunction

	function automatic bit in_raster(int x, int y);
		return x >= 0 && y >= 0 && x < used_extent(raster_cols, MAX_W) &&
			y < used_extent(raster_rows, MAX_H);
	endfunction

	function automatic bit cell_is_black(int x, int y);
		return in_raster(x, y) && map_black_bits[y*MAX_W + x];
	endfunction

	// Bresenham walk from start to end, both ends included; stops at the first black cell.
	function automatic bit segment_touches_black(int xa, int ya, int xb, int yb);
		int dx, dy, sx, sy, err, e2, x, y;
		dx  = (xb > xa) ? xb - xa : xa - xb;
		dy  = -((yb > ya) ? yb - ya : ya - yb);
		sx  = (xa < xb) ? 1 : -1;
		sy  = (ya < yb) ? 1 : -1;
		err = dx + dy;
		x   = xa;
		y   = ya;
		while (1) begin
			if (cell_is_black(x, y))
				return 1'b1;
			if (x == xb && y == yb)
				return 1'b0;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy;
				x   += sx;
			end
			if (e2 <= dx) begin
				err += dx;
				y   += sy;
			end
		end
	endfunction

	// Applies one request to the predicted state; returns 1 when it yields a result.
	function automatic bit predict_probe(input probe_req_t rq, output probe_res_t r);
		r = '0;
		if (rq.kind == sbcp_pkg::REQ_WRITE) begin
			if (in_raster(rq.cell_x, rq.cell_y))
				map_black_bits[rq.cell_y*MAX_W + rq.cell_x] = (rq.cls == sbcp_pkg::CLASS_BLACK);
			return 1'b0;
		end
		if (!raster_on || !in_raster(rq.sx, rq.sy) || !in_raster(rq.ex, rq.ey)) begin
			r.endpoint_outside = 1'b1;
			return 1'b1;
		end
		r.touches_black = segment_touches_black(rq.sx, rq.sy, rq.ex, rq.ey);
		return 1'b1;
	endfunction

	function automatic sbcp_pkg::coord_t in_window(int org, int span);
		return sbcp_pkg::coord_t'(org + $urandom_range(0, span - 1));
	endfunction

	// Directed table builders; ignored coordinates carry all-ones and a query the black class.
	function automatic void add_cfg(sbcp_pkg::cfg_index_t idx, sbcp_pkg::dim_t data);
		step_row_t row;
		row        = '0;
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.data   = data;
		directed_steps.push_back(row);
	endfunction

	function automatic void add_write(sbcp_pkg::coord_t x, sbcp_pkg::coord_t y,
			sbcp_pkg::cell_class_t cls);
		step_row_t row;
		row           = '0;
		row.rq.kind   = sbcp_pkg::REQ_WRITE;
		row.rq.cell_x = x;
		row.rq.cell_y = y;
		row.rq.cls    = cls;
		row.rq.sx     = 8'hFF;
		row.rq.sy     = 8'hFF;
		row.rq.ex     = 8'hFF;
		row.rq.ey     = 8'hFF;
		directed_steps.push_back(row);
	endfunction

	function automatic void add_query(sbcp_pkg::coord_t sx, sbcp_pkg::coord_t sy,
			sbcp_pkg::coord_t ex, sbcp_pkg::coord_t ey,
			bit typed = 1'b0, bit hit = 1'b0, bit outside = 1'b0);
		step_row_t row;
		row                       = '0;
		row.rq.kind               = sbcp_pkg::REQ_QUERY;
		row.rq.cell_x             = 8'hFF;
		row.rq.cell_y             = 8'hFF;
		row.rq.cls                = sbcp_pkg::CLASS_BLACK;
		row.rq.sx                 = sx;
		row.rq.sy                 = sy;
		row.rq.ex                 = ex;
		row.rq.ey                 = ey;
		row.typed                 = typed;
		row.want.touches_black    = hit;
		row.want.endpoint_outside = outside;
		directed_steps.push_back(row);
	endfunction

	// Offers one request after a random gap while idling is on; records any expected result on acceptance.
	task automatic push_request(probe_req_t rq, bit typed, probe_res_t want);
		int         gap;
		probe_res_t r;
		gap = idling_on ? $urandom_range(0, 10) : 0;
		@(negedge clk);
		if (gap != 0) begin
			req_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.req_type   = rq.kind;
		req_bus.cell_x     = rq.cell_x;
		req_bus.cell_y     = rq.cell_y;
		req_bus.cell_class = rq.cls;
		req_bus.start_x    = rq.sx;
		req_bus.start_y    = rq.sy;
		req_bus.end_x      = rq.ex;
		req_bus.end_y      = rq.ey;
		req_bus.valid      = 1'b1;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		if (predict_probe(rq, r))
			expected_probe_results.push_back(typed ? want : r);
	endtask

	// Stops offering requests and waits until every expected result has arrived.
	task automatic drain_results();
		@(negedge clk);
		req_bus.valid = 1'b0;
		while (expected_probe_results.size() != 0) @(posedge clk);
		repeat (WRITE_SETTLE) @(posedge clk);
	endtask

	// Register write, offered only after the expected results have drained, so the block is idle.
	task automatic write_register(sbcp_pkg::cfg_index_t idx, sbcp_pkg::dim_t value);
		drain_results();
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data  = value;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		case (idx)
			sbcp_pkg::REG_RASTER_VALID:  raster_on   = value[0];
			sbcp_pkg::REG_RASTER_WIDTH:  raster_cols = value;
			sbcp_pkg::REG_RASTER_HEIGHT: raster_rows = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// Result side: random stall before each result while idling is on, one long hold-off on request.
	initial begin
		int         stall;
		probe_res_t seen;
		probe_res_t want;
		res_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = idling_on ? $urandom_range(0, 10) : 0;
			if (hold_results) begin
				stall        = HOLD_CYCLES;
				hold_results = 1'b0;
			end
			@(negedge clk);
			if (stall != 0) begin
				res_bus.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_bus.ready = 1'b1;
			do @(posedge clk); while (res_bus.valid !== 1'b1);
			seen.touches_black    = res_bus.touches_black;
			seen.endpoint_outside = res_bus.endpoint_outside;
			if (expected_probe_results.size() == 0) begin
				$display("%0t: result with none expected: touches_black %b endpoint_outside %b",
					$time, seen.touches_black, seen.endpoint_outside);
				mismatch_count++;
			end else begin
				want = expected_probe_results.pop_front();
				if (seen.touches_black !== want.touches_black) begin
					$display("%0t: touches_black expected %b, got %b",
						$time, want.touches_black, seen.touches_black);
					mismatch_count++;
				end
				if (seen.endpoint_outside !== want.endpoint_outside) begin
					$display("%0t: endpoint_outside expected %b, got %b",
						$time, want.endpoint_outside, seen.endpoint_outside);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus: reset, directed table, then random phases over several raster settings.
	initial begin
		probe_req_t     rq;
		sbcp_pkg::dim_t w, h, cfg_word;
		int             lw, lh, win, ox, oy, spx, spy;

		raster_on      = 1'b0;
		raster_cols    = 9'd2;
		raster_rows    = 9'd2;
		mismatch_count = 0;
		idling_on      = 1'b1;
		hold_results   = 1'b0;

		req_bus.valid      = 1'b0;
		req_bus.req_type   = sbcp_pkg::REQ_WRITE;
		req_bus.cell_x     = '0;
		req_bus.cell_y     = '0;
		req_bus.cell_class = '0;
		req_bus.start_x    = '0;
		req_bus.start_y    = '0;
		req_bus.end_x      = '0;
		req_bus.end_y      = '0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.index      = sbcp_pkg::REG_RASTER_VALID;
		cfg_bus.data       = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Query before the raster is marked valid.
		add_query(0, 0, 1, 1, 1'b1, 1'b0, 1'b1);
		add_cfg(sbcp_pkg::REG_RASTER_VALID, 9'd1);
		add_query(0, 0, 1, 1, 1'b1, 1'b0, 1'b0);
		add_write(1, 1, sbcp_pkg::CLASS_BLACK);
		add_query(0, 0, 1, 1, 1'b1, 1'b1, 1'b0);
		// Write outside the 2x2 raster is dropped.
		add_write(2, 0, sbcp_pkg::CLASS_BLACK);
		add_query(0, 0, 1, 0);
		add_query(2, 0, 0, 0, 1'b1, 1'b0, 1'b1);
		// Full-size raster and the far corner.
		add_cfg(sbcp_pkg::REG_RASTER_WIDTH, 9'd256);
		add_cfg(sbcp_pkg::REG_RASTER_HEIGHT, 9'd256);
		add_write(255, 255, sbcp_pkg::CLASS_BLACK);
		add_query(0, 0, 255, 255, 1'b1, 1'b1, 1'b0);
		add_write(255, 255, CLS_WHITE);
		add_query(255, 255, 255, 255, 1'b1, 1'b0, 1'b0);
		add_write(128, 0, sbcp_pkg::CLASS_BLACK);
		add_query(0, 0, 255, 0);
		add_write(128, 0, CLS_INVALID);
		add_write(10, 10, CLS_UNKNOWN);
		add_query(255, 0, 0, 255);
		// Writes are stored while the raster is invalid; queries are refused.
		add_cfg(sbcp_pkg::REG_RASTER_VALID, 9'd0);
		add_write(5, 5, sbcp_pkg::CLASS_BLACK);
		add_query(5, 5, 5, 5, 1'b1, 1'b0, 1'b1);
		add_cfg(sbcp_pkg::REG_RASTER_VALID, 9'd1);
		add_query(5, 5, 5, 5, 1'b1, 1'b1, 1'b0);
		// Zero width puts nothing in bounds.
		add_cfg(sbcp_pkg::REG_RASTER_WIDTH, 9'd0);
		add_query(0, 0, 0, 0, 1'b1, 1'b0, 1'b1);
		add_write(0, 0, sbcp_pkg::CLASS_BLACK);
		// Single column, height above the map limit.
		add_cfg(sbcp_pkg::REG_RASTER_WIDTH, 9'd1);
		add_cfg(sbcp_pkg::REG_RASTER_HEIGHT, 9'd511);
		add_write(0, 200, sbcp_pkg::CLASS_BLACK);
		add_query(0, 0, 0, 255);
		add_query(1, 0, 0, 0, 1'b1, 1'b0, 1'b1);
		add_cfg(REG_SPARE, 9'd511);
		add_cfg(sbcp_pkg::REG_RASTER_WIDTH, 9'd256);
		add_cfg(sbcp_pkg::REG_RASTER_HEIGHT, 9'd256);
		add_query(0, 0, 0, 0);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_cfg)
				write_register(directed_steps[i].idx, directed_steps[i].data);
			else
				push_request(directed_steps[i].rq, directed_steps[i].typed,
					directed_steps[i].want);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ((phase < 4) ? phase : $urandom_range(4, 9))
				0: begin w = 9'd256; h = 9'd256; end
				1: begin w = 9'd2;   h = 9'd2;   end
				2: begin w = 9'd2;   h = 9'd256; end
				3: begin w = 9'd256; h = 9'd2;   end
				4: begin
					w = sbcp_pkg::dim_t'($urandom_range(257, 511));
					h = sbcp_pkg::dim_t'($urandom_range(0, 511));
				end
				5: begin
					w = sbcp_pkg::dim_t'($urandom_range(0, 1));
					h = sbcp_pkg::dim_t'($urandom_range(2, 256));
				end
				6: begin
					w = sbcp_pkg::dim_t'($urandom_range(2, 256));
					h = sbcp_pkg::dim_t'($urandom_range(0, 1));
				end
				default: begin
					w = sbcp_pkg::dim_t'($urandom_range(2, 40));
					h = sbcp_pkg::dim_t'($urandom_range(2, 40));
				end
			endcase
			write_register(sbcp_pkg::REG_RASTER_WIDTH, w);
			write_register(sbcp_pkg::REG_RASTER_HEIGHT, h);
			cfg_word    = sbcp_pkg::dim_t'($urandom_range(0, 511));
			cfg_word[0] = (phase < 4) || ($urandom_range(0, 7) != 0);
			write_register(sbcp_pkg::REG_RASTER_VALID, cfg_word);
			if ($urandom_range(0, 3) == 0)
				write_register(REG_SPARE, sbcp_pkg::dim_t'($urandom_range(0, 511)));

			// Most traffic lands in a small window of the raster so that hits are common.
			lw  = used_extent(w, MAX_W);
			lh  = used_extent(h, MAX_H);
			win = ($urandom_range(0, 7) == 0) ? 256 : $urandom_range(2, 16);
			ox  = (lw == 0) ? 0 : $urandom_range(0, lw - 1);
			oy  = (lh == 0) ? 0 : $urandom_range(0, lh - 1);
			spx = (lw == 0) ? 256 : ((lw - ox < win) ? lw - ox : win);
			spy = (lh == 0) ? 256 : ((lh - oy < win) ? lh - oy : win);

			idling_on = (phase % 3 != 2);
			if (phase == 3)
				hold_results = 1'b1;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					drain_results();
				rq.kind   = ($urandom_range(0, 9) < 4) ? sbcp_pkg::REQ_WRITE
					: sbcp_pkg::REQ_QUERY;
				rq.cell_x = sbcp_pkg::coord_t'($urandom_range(0, 255));
				rq.cell_y = sbcp_pkg::coord_t'($urandom_range(0, 255));
				rq.cls    = ($urandom_range(0, 2) == 0) ? sbcp_pkg::CLASS_BLACK
					: sbcp_pkg::cell_class_t'($urandom_range(0, 3));
				rq.sx     = sbcp_pkg::coord_t'($urandom_range(0, 255));
				rq.sy     = sbcp_pkg::coord_t'($urandom_range(0, 255));
				rq.ex     = sbcp_pkg::coord_t'($urandom_range(0, 255));
				rq.ey     = sbcp_pkg::coord_t'($urandom_range(0, 255));
				if ($urandom_range(0, 6) != 0) begin
					rq.cell_x = in_window(ox, spx);
					rq.cell_y = in_window(oy, spy);
					rq.sx     = in_window(ox, spx);
					rq.sy     = in_window(oy, spy);
					rq.ex     = in_window(ox, spx);
					rq.ey     = in_window(oy, spy);
				end
				push_request(rq, 1'b0, '0);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
